// ===== rtl/spti_pkg.sv =====
// Shared types, codes and constants of the sensor pose timestamp interpolator.
`default_nettype none
package spti_pkg;

  localparam int REF_DEPTH_DEF    = 64;
  localparam int SENSOR_DEPTH_DEF = 64;
  localparam int CAP_RESET        = 64;
  localparam int STAMP_W          = 48;
  localparam int TAG_W            = 32;
  localparam int POS_W            = 32;
  localparam int ANG_W            = 16;
  localparam int FRAC_W           = 17;
  localparam int OPND_W           = 34;

  localparam logic [1:0] MODE_REF = 2'd0;
  localparam logic [1:0] MODE_SEN = 2'd1;
  localparam logic [1:0] MODE_REQ = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FEW_REFS  = 2'd1;
  localparam logic [1:0] ST_UNCOVERED = 2'd2;

  localparam logic REG_REF_CAP = 1'b0;
  localparam logic REG_SEN_CAP = 1'b1;

  localparam logic [2:0] FLD_X     = 3'd0;
  localparam logic [2:0] FLD_Y     = 3'd1;
  localparam logic [2:0] FLD_Z     = 3'd2;
  localparam logic [2:0] FLD_ROLL  = 3'd3;
  localparam logic [2:0] FLD_PITCH = 3'd4;
  localparam logic [2:0] FLD_YAW   = 3'd5;

  typedef struct packed {
    logic        [STAMP_W-1:0] t;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic signed [POS_W-1:0]   z;
    logic signed [ANG_W-1:0]   roll;
    logic signed [ANG_W-1:0]   pitch;
    logic signed [ANG_W-1:0]   yaw;
  } ref_row_t;

  typedef struct packed {
    logic [STAMP_W-1:0] t;
    logic [TAG_W-1:0]   tag;
  } sen_row_t;

  typedef struct packed {
    logic               start;
    logic [STAMP_W-1:0] num;
    logic [STAMP_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_R_EVICT,
    S_R_FRONT_RD,
    S_R_FRONT,
    S_R_RD,
    S_R_CMP,
    S_R_WR,
    S_S_PUSH,
    S_S_WR,
    S_Q_CHECK,
    S_Q_T0,
    S_Q_TN,
    S_Q_SRD,
    S_Q_SCMP,
    S_Q_IRD,
    S_Q_ICMP,
    S_Q_H1RD,
    S_Q_H1,
    S_Q_DIV,
    S_Q_MUL,
    S_Q_ACC,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/spti_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
`default_nettype none
module spti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/spti_div.sv =====
// Restoring divider that produces the Q16 interpolation fraction one bit per cycle.
`default_nettype none
module spti_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spti_pkg::div_req_t req,
  output spti_pkg::div_rsp_t     rsp
);

  localparam int SW = spti_pkg::STAMP_W;
  localparam int QW = spti_pkg::FRAC_W;

  logic          busy;
  logic [4:0]    cnt;
  logic          den_zero;
  logic [SW:0]   rem;
  logic [SW-1:0] den;
  logic [QW-1:0] quo;
  logic          done;
  logic          ge;
  logic [SW:0]   rem_sub;

  assign ge      = rem >= {1'b0, den};
  assign rem_sub = ge ? (rem - {1'b0, den}) : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(QW);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= {1'b0, req.num};
      den      <= req.den;
      den_zero <= req.den == '0;
      quo      <= '0;
    end else if (busy) begin
      quo <= {quo[QW-2:0], ge};
      rem <= {rem_sub[SW-1:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = den_zero ? '0 : quo;

endmodule
`default_nettype wire

// ===== rtl/spti_mac.sv =====
// Shared multiply and round unit that forms b + round(d * f / 65536).
`default_nettype none
module spti_mac (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [spti_pkg::OPND_W-1:0]   base,
  input  wire logic signed [spti_pkg::OPND_W-1:0]   delta,
  input  wire logic        [spti_pkg::FRAC_W-1:0]   frac,
  output logic signed      [spti_pkg::OPND_W-1:0]   result
);

  localparam int OW = spti_pkg::OPND_W;
  localparam int PW = OW + spti_pkg::FRAC_W + 1;

  logic signed [OW-1:0] base_q;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] rounded;

  always_ff @(posedge clk) begin
    if (en) begin
      base_q <= base;
      prod_q <= delta * $signed({1'b0, frac});
    end
  end

  assign rounded = prod_q + PW'(32768);
  assign result  = base_q + rounded[OW+15:16];

endmodule
`default_nettype wire

// ===== rtl/sensor_pose_timestamp_interpolator.sv =====
// Top level: reference and sensor queues, sequencer and interpolation datapath.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  mode stamp sensor_tag pos_* *_angle
//   output   out        out_valid/out_stall  status out_tag out_stamp out_*
//   config   in         psel/penable/pready  paddr pwdata prdata
//
// A reference push stalls the input while it moves past each later stored entry and writes the
// new row; when the queue is full it first reads the oldest entry and drops it or the new row.
// A sensor push stalls while it makes room and writes the item; a request stalls while it
// discards stale sensor items, examines references, waits for any divider result and runs the
// six field interpolations through the one shared multiplier, plus any output stall.
// Synchronous reset sets the state, heads, counts and capacities; the memories need no clearing.
// The block takes one item at a time and holds the result in an output register.
`default_nettype none
module sensor_pose_timestamp_interpolator #(
  parameter int REF_DEPTH    = spti_pkg::REF_DEPTH_DEF,
  parameter int SENSOR_DEPTH = spti_pkg::SENSOR_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          mode,
  input  wire logic [47:0]         stamp,
  input  wire logic [31:0]         sensor_tag,
  input  wire logic signed [31:0]  pos_x,
  input  wire logic signed [31:0]  pos_y,
  input  wire logic signed [31:0]  pos_z,
  input  wire logic signed [15:0]  roll_angle,
  input  wire logic signed [15:0]  pitch_angle,
  input  wire logic signed [15:0]  yaw_angle,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic [31:0]              out_tag,
  output logic [47:0]              out_stamp,
  output logic signed [31:0]       out_x,
  output logic signed [31:0]       out_y,
  output logic signed [31:0]       out_z,
  output logic signed [15:0]       out_roll,
  output logic signed [15:0]       out_pitch,
  output logic signed [15:0]       out_yaw,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int RAW = $clog2(REF_DEPTH);
  localparam int RCW = $clog2(REF_DEPTH + 1);
  localparam int SAW = (SENSOR_DEPTH > 1) ? $clog2(SENSOR_DEPTH) : 1;
  localparam int SCW = $clog2(SENSOR_DEPTH + 1);
  localparam int RCAP_RST = (spti_pkg::CAP_RESET > REF_DEPTH) ? REF_DEPTH : spti_pkg::CAP_RESET;
  localparam int SCAP_RST = (spti_pkg::CAP_RESET > SENSOR_DEPTH) ? SENSOR_DEPTH
                                                                  : spti_pkg::CAP_RESET;
  localparam int OW = spti_pkg::OPND_W;

  function automatic logic [RAW-1:0] rphys(input logic [RAW-1:0] h, input logic [RCW-1:0] idx);
    logic [RAW:0] s;
    s = {1'b0, h} + (RAW+1)'(idx);
    if (s >= (RAW+1)'(REF_DEPTH)) begin
      s = s - (RAW+1)'(REF_DEPTH);
    end
    return s[RAW-1:0];
  endfunction

  function automatic logic [SAW-1:0] sphys(input logic [SAW-1:0] h, input logic [SCW-1:0] idx);
    logic [SAW:0] s;
    s = {1'b0, h} + (SAW+1)'(idx);
    if (s >= (SAW+1)'(SENSOR_DEPTH)) begin
      s = s - (SAW+1)'(SENSOR_DEPTH);
    end
    return s[SAW-1:0];
  endfunction

  spti_pkg::state_t state, state_next;

  logic [RCW-1:0] ref_cap;
  logic [SCW-1:0] sen_cap;
  logic [RAW-1:0] ref_head;
  logic [RCW-1:0] ref_count;
  logic [SAW-1:0] sen_head;
  logic [SCW-1:0] sen_count;

  logic [47:0]                    stamp_q;
  logic [31:0]                    tag_q;
  spti_pkg::ref_row_t             new_row;
  logic [RCW-1:0]                 j_idx;
  logic [47:0]                    t_first;
  logic [47:0]                    t_last;
  logic [47:0]                    s_time;
  logic [31:0]                    s_tag;
  spti_pkg::ref_row_t             prev_row;
  spti_pkg::ref_row_t             lo_row;
  spti_pkg::ref_row_t             hi_row;
  logic [spti_pkg::FRAC_W-1:0]    frac;
  logic [2:0]                     fld;

  logic [1:0]          r_status;
  logic signed [31:0]  r_x, r_y, r_z;
  logic signed [15:0]  r_roll, r_pitch, r_yaw;

  logic               ref_we;
  logic [RAW-1:0]     ref_waddr;
  spti_pkg::ref_row_t ref_wdata;
  logic [RAW-1:0]     ref_raddr;
  spti_pkg::ref_row_t ref_rd;
  logic               sen_we;
  logic [SAW-1:0]     sen_waddr;
  spti_pkg::sen_row_t sen_wdata;
  logic [SAW-1:0]     sen_raddr;
  spti_pkg::sen_row_t sen_rd;

  spti_pkg::div_req_t div_req;
  spti_pkg::div_rsp_t div_rsp;

  logic                 mac_en;
  logic signed [OW-1:0] mac_base;
  logic signed [OW-1:0] mac_delta;
  logic signed [OW-1:0] mac_res;
  logic signed [OW-1:0] op_a;
  logic signed [OW-1:0] yaw_d;

  logic in_xfer;
  logic out_free;
  logic search_more;
  logic [31:0] wval;
  logic cfg_we;

  assign in_stall    = state != spti_pkg::S_IDLE;
  assign in_xfer     = in_valid && !in_stall;
  assign out_free    = !out_valid || !out_stall;
  assign search_more = (j_idx < ref_count - RCW'(1)) && (ref_rd.t < s_time);
  assign pready      = 1'b1;
  assign cfg_we      = psel && penable && pwrite && pready;
  assign wval        = {25'd0, pwdata[6:0]};
  assign prdata      = (paddr[2] == spti_pkg::REG_SEN_CAP) ? 32'(sen_cap) : 32'(ref_cap);

  spti_ram #(.WIDTH($bits(spti_pkg::ref_row_t)), .DEPTH(REF_DEPTH)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .raddr (ref_raddr),
    .rdata (ref_rd)
  );

  spti_ram #(.WIDTH($bits(spti_pkg::sen_row_t)), .DEPTH(SENSOR_DEPTH)) u_sen_ram (
    .clk   (clk),
    .we    (sen_we),
    .waddr (sen_waddr),
    .wdata (sen_wdata),
    .raddr (sen_raddr),
    .rdata (sen_rd)
  );

  spti_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  spti_mac u_mac (
    .clk    (clk),
    .en     (mac_en),
    .base   (mac_base),
    .delta  (mac_delta),
    .frac   (frac),
    .result (mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_cap <= RCW'(RCAP_RST);
      sen_cap <= SCW'(SCAP_RST);
    end else if (cfg_we) begin
      if (paddr[2] == spti_pkg::REG_REF_CAP) begin
        if (wval < 32'd2) begin
          ref_cap <= RCW'(2);
        end else if (wval > 32'(REF_DEPTH)) begin
          ref_cap <= RCW'(REF_DEPTH);
        end else begin
          ref_cap <= RCW'(wval);
        end
      end else begin
        if (wval < 32'd1) begin
          sen_cap <= SCW'(1);
        end else if (wval > 32'(SENSOR_DEPTH)) begin
          sen_cap <= SCW'(SENSOR_DEPTH);
        end else begin
          sen_cap <= SCW'(wval);
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spti_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (mode)
            spti_pkg::MODE_REF: state_next = spti_pkg::S_R_EVICT;
            spti_pkg::MODE_SEN: state_next = spti_pkg::S_S_PUSH;
            spti_pkg::MODE_REQ: state_next = spti_pkg::S_Q_CHECK;
            default:            state_next = spti_pkg::S_IDLE;
          endcase
        end
      end
      spti_pkg::S_R_EVICT: begin
        state_next = (ref_count >= ref_cap) ? spti_pkg::S_R_FRONT_RD : spti_pkg::S_R_RD;
      end
      spti_pkg::S_R_FRONT_RD: state_next = spti_pkg::S_R_FRONT;
      spti_pkg::S_R_FRONT: begin
        state_next = (stamp_q < ref_rd.t) ? spti_pkg::S_IDLE : spti_pkg::S_R_RD;
      end
      spti_pkg::S_R_RD: begin
        state_next = (j_idx == '0) ? spti_pkg::S_R_WR : spti_pkg::S_R_CMP;
      end
      spti_pkg::S_R_CMP: begin
        state_next = (stamp_q < ref_rd.t) ? spti_pkg::S_R_RD : spti_pkg::S_R_WR;
      end
      spti_pkg::S_R_WR:   state_next = spti_pkg::S_IDLE;
      spti_pkg::S_S_PUSH: state_next = spti_pkg::S_S_WR;
      spti_pkg::S_S_WR:   state_next = spti_pkg::S_IDLE;
      spti_pkg::S_Q_CHECK: begin
        state_next = (ref_count <= RCW'(1)) ? spti_pkg::S_OUT : spti_pkg::S_Q_T0;
      end
      spti_pkg::S_Q_T0: state_next = spti_pkg::S_Q_TN;
      spti_pkg::S_Q_TN: state_next = spti_pkg::S_Q_SRD;
      spti_pkg::S_Q_SRD: begin
        state_next = (sen_count == '0) ? spti_pkg::S_OUT : spti_pkg::S_Q_SCMP;
      end
      spti_pkg::S_Q_SCMP: begin
        if (sen_rd.t < t_first) begin
          state_next = spti_pkg::S_Q_SRD;
        end else if (sen_rd.t > t_last) begin
          state_next = spti_pkg::S_OUT;
        end else begin
          state_next = spti_pkg::S_Q_IRD;
        end
      end
      spti_pkg::S_Q_IRD: state_next = spti_pkg::S_Q_ICMP;
      spti_pkg::S_Q_ICMP: begin
        if (search_more) begin
          state_next = spti_pkg::S_Q_IRD;
        end else if (j_idx == '0) begin
          state_next = spti_pkg::S_Q_H1RD;
        end else begin
          state_next = spti_pkg::S_Q_DIV;
        end
      end
      spti_pkg::S_Q_H1RD: state_next = spti_pkg::S_Q_H1;
      spti_pkg::S_Q_H1:   state_next = spti_pkg::S_Q_MUL;
      spti_pkg::S_Q_DIV: begin
        if (div_rsp.done) begin
          state_next = spti_pkg::S_Q_MUL;
        end
      end
      spti_pkg::S_Q_MUL: state_next = spti_pkg::S_Q_ACC;
      spti_pkg::S_Q_ACC: begin
        state_next = (fld == spti_pkg::FLD_YAW) ? spti_pkg::S_OUT : spti_pkg::S_Q_MUL;
      end
      spti_pkg::S_OUT: begin
        if (out_free) begin
          state_next = spti_pkg::S_IDLE;
        end
      end
      default: state_next = spti_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_a     = '0;
    mac_base = '0;
    case (fld)
      spti_pkg::FLD_X: begin
        mac_base = OW'(lo_row.x);
        op_a     = OW'(hi_row.x);
      end
      spti_pkg::FLD_Y: begin
        mac_base = OW'(lo_row.y);
        op_a     = OW'(hi_row.y);
      end
      spti_pkg::FLD_Z: begin
        mac_base = OW'(lo_row.z);
        op_a     = OW'(hi_row.z);
      end
      spti_pkg::FLD_ROLL: begin
        mac_base = OW'(lo_row.roll);
        op_a     = OW'(hi_row.roll);
      end
      spti_pkg::FLD_PITCH: begin
        mac_base = OW'(lo_row.pitch);
        op_a     = OW'(hi_row.pitch);
      end
      spti_pkg::FLD_YAW: begin
        mac_base = OW'(lo_row.yaw);
        op_a     = OW'(hi_row.yaw);
      end
      default: begin
        mac_base = '0;
        op_a     = '0;
      end
    endcase
  end

  assign yaw_d = op_a - mac_base;

  always_comb begin
    mac_delta = yaw_d;
    if (fld == spti_pkg::FLD_YAW) begin
      if (yaw_d > OW'(32768)) begin
        mac_delta = yaw_d - OW'(65536);
      end else if (yaw_d < -OW'(32768)) begin
        mac_delta = yaw_d + OW'(65536);
      end
    end
  end

  always_comb begin
    ref_we      = 1'b0;
    ref_waddr   = rphys(ref_head, j_idx);
    ref_wdata   = new_row;
    ref_raddr   = rphys(ref_head, '0);
    sen_we      = 1'b0;
    sen_waddr   = sphys(sen_head, sen_count);
    sen_wdata   = '{t: stamp_q, tag: tag_q};
    sen_raddr   = sen_head;
    div_req     = '{start: 1'b0, num: s_time - prev_row.t, den: ref_rd.t - prev_row.t};
    mac_en      = 1'b0;
    case (state)
      spti_pkg::S_R_RD: ref_raddr = rphys(ref_head, j_idx - RCW'(1));
      spti_pkg::S_R_CMP: begin
        ref_we    = stamp_q < ref_rd.t;
        ref_wdata = ref_rd;
      end
      spti_pkg::S_R_WR: ref_we = 1'b1;
      spti_pkg::S_S_WR: sen_we = 1'b1;
      spti_pkg::S_Q_T0: ref_raddr = rphys(ref_head, ref_count - RCW'(1));
      spti_pkg::S_Q_IRD: ref_raddr = rphys(ref_head, j_idx);
      spti_pkg::S_Q_ICMP: div_req.start = !search_more && (j_idx != '0);
      spti_pkg::S_Q_H1RD: ref_raddr = rphys(ref_head, RCW'(1));
      spti_pkg::S_Q_MUL: mac_en = 1'b1;
      default: ref_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spti_pkg::S_IDLE;
      ref_head  <= '0;
      ref_count <= '0;
      sen_head  <= '0;
      sen_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= ((state == spti_pkg::S_OUT) && out_free) || (out_valid && out_stall);
      case (state)
        spti_pkg::S_R_EVICT: begin
          if (ref_count >= ref_cap) begin
            ref_head  <= rphys(ref_head, ref_count - ref_cap);
            ref_count <= ref_cap;
          end
        end
        spti_pkg::S_R_FRONT: begin
          if (!(stamp_q < ref_rd.t)) begin
            ref_head  <= rphys(ref_head, RCW'(1));
            ref_count <= ref_count - RCW'(1);
          end
        end
        spti_pkg::S_R_WR: ref_count <= ref_count + RCW'(1);
        spti_pkg::S_S_PUSH: begin
          if (sen_count >= sen_cap) begin
            sen_head  <= sphys(sen_head, sen_count - sen_cap + SCW'(1));
            sen_count <= sen_cap - SCW'(1);
          end
        end
        spti_pkg::S_S_WR: sen_count <= sen_count + SCW'(1);
        spti_pkg::S_Q_SCMP: begin
          if ((sen_rd.t < t_first) || !(sen_rd.t > t_last)) begin
            sen_head  <= sphys(sen_head, SCW'(1));
            sen_count <= sen_count - SCW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      spti_pkg::S_IDLE: begin
        if (in_xfer) begin
          stamp_q  <= stamp;
          tag_q    <= sensor_tag;
          new_row  <= '{t: stamp, x: pos_x, y: pos_y, z: pos_z,
                        roll: roll_angle, pitch: pitch_angle, yaw: yaw_angle};
          r_status <= spti_pkg::ST_OK;
          s_time   <= '0;
          s_tag    <= '0;
          r_x      <= '0;
          r_y      <= '0;
          r_z      <= '0;
          r_roll   <= '0;
          r_pitch  <= '0;
          r_yaw    <= '0;
        end
      end
      spti_pkg::S_R_EVICT: begin
        j_idx <= (ref_count >= ref_cap) ? ref_cap - RCW'(1) : ref_count;
      end
      spti_pkg::S_R_CMP: begin
        if (stamp_q < ref_rd.t) begin
          j_idx <= j_idx - RCW'(1);
        end
      end
      spti_pkg::S_Q_CHECK: begin
        if (ref_count <= RCW'(1)) begin
          r_status <= spti_pkg::ST_FEW_REFS;
        end
      end
      spti_pkg::S_Q_T0: t_first <= ref_rd.t;
      spti_pkg::S_Q_TN: t_last <= ref_rd.t;
      spti_pkg::S_Q_SRD: begin
        if (sen_count == '0) begin
          r_status <= spti_pkg::ST_UNCOVERED;
        end
      end
      spti_pkg::S_Q_SCMP: begin
        if (!(sen_rd.t < t_first)) begin
          if (sen_rd.t > t_last) begin
            r_status <= spti_pkg::ST_UNCOVERED;
          end else begin
            s_time <= sen_rd.t;
            s_tag  <= sen_rd.tag;
            j_idx  <= '0;
          end
        end
      end
      spti_pkg::S_Q_ICMP: begin
        fld <= spti_pkg::FLD_X;
        if (search_more) begin
          prev_row <= ref_rd;
          j_idx    <= j_idx + RCW'(1);
        end else if (j_idx == '0) begin
          lo_row <= ref_rd;
          frac   <= '0;
        end else begin
          lo_row <= prev_row;
          hi_row <= ref_rd;
        end
      end
      spti_pkg::S_Q_H1: hi_row <= ref_rd;
      spti_pkg::S_Q_DIV: begin
        if (div_rsp.done) begin
          frac <= div_rsp.quo;
        end
      end
      spti_pkg::S_Q_ACC: begin
        fld <= fld + 3'd1;
        case (fld)
          spti_pkg::FLD_X:     r_x     <= mac_res[31:0];
          spti_pkg::FLD_Y:     r_y     <= mac_res[31:0];
          spti_pkg::FLD_Z:     r_z     <= mac_res[31:0];
          spti_pkg::FLD_ROLL:  r_roll  <= mac_res[15:0];
          spti_pkg::FLD_PITCH: r_pitch <= mac_res[15:0];
          default:             r_yaw   <= mac_res[15:0];
        endcase
      end
      spti_pkg::S_OUT: begin
        if (out_free) begin
          status    <= r_status;
          out_tag   <= s_tag;
          out_stamp <= s_time;
          out_x     <= r_x;
          out_y     <= r_y;
          out_z     <= r_z;
          out_roll  <= r_roll;
          out_pitch <= r_pitch;
          out_yaw   <= r_yaw;
        end
      end
      default: fld <= fld;
    endcase
  end

`ifndef SYNTHESIS
  a_ref_count_bound: assert property (@(posedge clk) disable iff (rst)
    ref_count <= RCW'(REF_DEPTH))
    else $error("reference count beyond depth");

  a_sen_count_bound: assert property (@(posedge clk) disable iff (rst)
    sen_count <= SCW'(SENSOR_DEPTH))
    else $error("sensor count beyond depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == spti_pkg::S_Q_DIV)
    else $error("divider finished outside its wait state");

  a_ref_insert_count: assert property (@(posedge clk) disable iff (rst)
    state == spti_pkg::S_R_WR |=> ref_count != '0)
    else $error("reference queue empty after insert");

  a_ok_needs_refs: assert property (@(posedge clk) disable iff (rst)
    (state == spti_pkg::S_OUT && r_status == spti_pkg::ST_OK) |-> ref_count > RCW'(1))
    else $error("good result with fewer than two references");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the sensor pose timestamp interpolator: predictor, scoreboard and stimulus.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic [1:0]                   mode;
    logic [spti_pkg::STAMP_W-1:0] stamp;
    logic [spti_pkg::TAG_W-1:0]   tag;
    logic signed [31:0]           x, y, z;
    logic signed [15:0]           roll, pitch, yaw;
  } pose_item_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [spti_pkg::TAG_W-1:0]   tag;
    logic [spti_pkg::STAMP_W-1:0] stamp;
    logic signed [31:0]           x;
    logic signed [31:0]           y;
    logic signed [31:0]           z;
    logic signed [15:0]           roll;
    logic signed [15:0]           pitch;
    logic signed [15:0]           yaw;
  } pose_result_t;

  class pose_scoreboard;
    spti_pkg::ref_row_t refs[$];
    spti_pkg::sen_row_t sensors[$];
    int                 ref_cap = spti_pkg::CAP_RESET;
    int                 sen_cap = spti_pkg::CAP_RESET;
    pose_result_t       expected_poses[$];
    int                 mismatches = 0;
    int                 checked = 0;
    int                 n_ok = 0, n_few = 0, n_uncovered = 0;

    function void set_capacity(logic reg_idx, int value);
      if (reg_idx == spti_pkg::REG_REF_CAP)
        ref_cap = (value < 2) ? 2 : (value > spti_pkg::REF_DEPTH_DEF ?
                                     spti_pkg::REF_DEPTH_DEF : value);
      else
        sen_cap = (value < 1) ? 1 : (value > spti_pkg::SENSOR_DEPTH_DEF ?
                                     spti_pkg::SENSOR_DEPTH_DEF : value);
    endfunction

    function longint blend(longint b, longint d, longint f);
      return b + ((d * f + 32768) >>> 16);
    endfunction

    function void note_input(pose_item_t it);
      spti_pkg::ref_row_t row;
      spti_pkg::sen_row_t srow;
      pose_result_t       res;
      int                 pos, i, lo, hi;
      logic [63:0]        num, den, scaled;
      longint             f, b, d;
      case (it.mode)
        spti_pkg::MODE_REF: begin
          row = '{t: it.stamp, x: it.x, y: it.y, z: it.z,
                  roll: it.roll, pitch: it.pitch, yaw: it.yaw};
          pos = refs.size();
          while (pos > 0 && it.stamp < refs[pos-1].t) pos--;
          refs.insert(pos, row);
          while (refs.size() > ref_cap) refs.delete(0);
        end
        spti_pkg::MODE_SEN: begin
          while (sensors.size() >= sen_cap) sensors.delete(0);
          srow = '{t: it.stamp, tag: it.tag};
          sensors.insert(sensors.size(), srow);
        end
        spti_pkg::MODE_REQ: begin
          res = '{status: spti_pkg::ST_OK, tag: '0, stamp: '0, x: '0, y: '0, z: '0,
                  roll: '0, pitch: '0, yaw: '0};
          if (refs.size() <= 1) begin
            res.status = spti_pkg::ST_FEW_REFS;
            n_few++;
          end else begin
            while (sensors.size() > 0 && sensors[0].t < refs[0].t) sensors.delete(0);
            if (sensors.size() == 0 || sensors[0].t > refs[refs.size()-1].t) begin
              res.status = spti_pkg::ST_UNCOVERED;
              n_uncovered++;
            end else begin
              srow = sensors[0];
              sensors.delete(0);
              i = 0;
              while (i < refs.size() - 1 && refs[i].t < srow.t) i++;
              lo = (i == 0) ? 0 : i - 1;
              hi = (i == 0) ? 1 : i;
              f = 0;
              if (i != 0) begin
                num = 64'(srow.t - refs[lo].t);
                den = 64'(refs[hi].t - refs[lo].t);
                scaled = num << 16;
                if (den != 0) f = longint'(scaled / den);
                if (f > 65536) f = 65536;
              end
              res.tag = srow.tag;
              res.stamp = srow.t;
              b = refs[lo].x; res.x = 32'(blend(b, longint'(refs[hi].x) - b, f));
              b = refs[lo].y; res.y = 32'(blend(b, longint'(refs[hi].y) - b, f));
              b = refs[lo].z; res.z = 32'(blend(b, longint'(refs[hi].z) - b, f));
              b = refs[lo].roll;
              res.roll = 16'(blend(b, longint'(refs[hi].roll) - b, f));
              b = refs[lo].pitch;
              res.pitch = 16'(blend(b, longint'(refs[hi].pitch) - b, f));
              b = refs[lo].yaw;
              d = longint'(refs[hi].yaw) - b;
              if (d > 32768) d -= 65536;
              else if (d < -32768) d += 65536;
              res.yaw = 16'(blend(b, d, f));
              n_ok++;
            end
          end
          expected_poses.insert(expected_poses.size(), res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(pose_result_t act);
      pose_result_t exp_r;
      checked++;
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result, status %0d", act.status);
        return;
      end
      exp_r = expected_poses[0];
      expected_poses.delete(0);
      if (exp_r !== act) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d expected st=%0d tag=%h t=%h x=%0d y=%0d z=%0d",
                   checked, exp_r.status, exp_r.tag, exp_r.stamp, exp_r.x, exp_r.y, exp_r.z);
          $display("       r=%0d p=%0d yaw=%0d", exp_r.roll, exp_r.pitch, exp_r.yaw);
          $display("       got st=%0d tag=%h t=%h x=%0d y=%0d z=%0d r=%0d p=%0d yaw=%0d",
                   act.status, act.tag, act.stamp, act.x, act.y, act.z,
                   act.roll, act.pitch, act.yaw);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = '0;
  logic [47:0] stamp = '0;
  logic [31:0] sensor_tag = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [1:0] status;
  logic [31:0] out_tag;
  logic [47:0] out_stamp;
  logic signed [31:0] out_x, out_y, out_z;
  logic signed [15:0] out_roll, out_pitch, out_yaw;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pose_scoreboard sb = new();
  logic [47:0] tnow = 48'd1000;
  logic [47:0] last_ref = 48'd1000;
  int  idle_cycles = 0;
  bit  pressure_go = 1'b0;
  bit  stim_done = 1'b0;
  int  n_items = 0;

  sensor_pose_timestamp_interpolator dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      sb.check_result('{status: status, tag: out_tag, stamp: out_stamp, x: out_x, y: out_y,
                        z: out_z, roll: out_roll, pitch: out_pitch, yaw: out_yaw});
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else if (!rst) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int mode_sel, run;
    bit hold_done;
    hold_done = 1'b0;
    @(negedge clk);
    while (!stim_done) begin
      if (pressure_go && !hold_done) begin
        out_stall = 1'b1;
        repeat (600) @(negedge clk);
        hold_done = 1'b1;
      end
      mode_sel = $urandom_range(0, 3);
      run = $urandom_range(1, 30);
      repeat (run) begin
        case (mode_sel)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 1) == 0);
          default: out_stall = 1'b1;
        endcase
        @(negedge clk);
      end
    end
    out_stall = 1'b0;
  end

  task automatic send_item(pose_item_t it);
    in_valid = 1'b1;
    mode = it.mode;
    stamp = it.stamp;
    sensor_tag = it.tag;
    pos_x = it.x;
    pos_y = it.y;
    pos_z = it.z;
    roll_angle = it.roll;
    pitch_angle = it.pitch;
    yaw_angle = it.yaw;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(it);
    n_items++;
    @(negedge clk);
  endtask

  task automatic pause_sender(int gap);
    in_valid = 1'b0;
    repeat (gap) @(negedge clk);
  endtask

  task automatic write_capacity(logic reg_idx, logic [31:0] value);
    in_valid = 1'b0;
    wait (sb.expected_poses.size() == 0);
    @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {reg_idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    sb.set_capacity(reg_idx, int'(value[6:0]));
  endtask

  function automatic pose_item_t make_pose(logic [1:0] m, logic [47:0] t);
    pose_item_t it;
    it.mode = m;
    it.stamp = t;
    it.tag = $urandom;
    it.x = $urandom;
    it.y = $urandom;
    it.z = $urandom;
    it.roll = 16'($urandom);
    it.pitch = 16'($urandom);
    it.yaw = 16'($urandom);
    return it;
  endfunction

  function automatic pose_item_t make_random();
    int sel, pick;
    logic [47:0] t;
    sel = $urandom_range(0, 99);
    pick = $urandom_range(0, 19);
    if (sel < 38) begin
      tnow = tnow + 48'($urandom_range(0, 60));
      if (pick == 0) t = 48'({$urandom, $urandom});
      else if (pick < 3) t = last_ref;
      else if (pick < 5) t = tnow - 48'($urandom_range(0, 200));
      else t = tnow;
      last_ref = t;
      return make_pose(spti_pkg::MODE_REF, t);
    end else if (sel < 70) begin
      if (pick == 0) t = 48'({$urandom, $urandom});
      else if (pick < 3) t = tnow + 48'($urandom_range(1, 100));
      else t = tnow - 48'($urandom_range(0, 300));
      return make_pose(spti_pkg::MODE_SEN, t);
    end else if (sel < 96) begin
      return make_pose(spti_pkg::MODE_REQ, 48'({$urandom, $urandom}));
    end
    return make_pose(MODE_NONE, 48'({$urandom, $urandom}));
  endfunction

  task automatic run_random(int count);
    int burst;
    while (count > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (burst) begin
        send_item(make_random());
        count--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
    end
  endtask

  initial begin
    pose_item_t it;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(make_pose(spti_pkg::MODE_REQ, 48'd0));
    it = make_pose(spti_pkg::MODE_REF, 48'd100);
    it.x = 32'sh80000000; it.y = 32'sh80000000; it.z = 32'sh7fffffff;
    it.roll = 16'sh8000; it.pitch = 16'sh7fff; it.yaw = 16'sh7fff;
    send_item(it);
    send_item(make_pose(spti_pkg::MODE_REQ, 48'd0));
    it = make_pose(spti_pkg::MODE_REF, 48'd300);
    it.x = 32'sh7fffffff; it.y = 32'sh7fffffff; it.z = 32'sh80000000;
    it.roll = 16'sh7fff; it.pitch = 16'sh8000; it.yaw = 16'sh8000;
    send_item(it);
    send_item(make_pose(spti_pkg::MODE_REF, 48'd300));
    send_item(make_pose(spti_pkg::MODE_SEN, 48'd50));
    send_item(make_pose(spti_pkg::MODE_SEN, 48'd100));
    send_item(make_pose(spti_pkg::MODE_SEN, 48'd200));
    send_item(make_pose(spti_pkg::MODE_SEN, 48'd300));
    send_item(make_pose(spti_pkg::MODE_SEN, 48'd301));
    repeat (5) send_item(make_pose(spti_pkg::MODE_REQ, 48'd0));
    send_item(make_pose(MODE_NONE, 48'hffffffffffff));
    send_item(make_pose(spti_pkg::MODE_REF, 48'hffffffffffff));
    send_item(make_pose(spti_pkg::MODE_SEN, 48'hfffffffffffe));
    send_item(make_pose(spti_pkg::MODE_SEN, 48'hffffffffffff));
    send_item(make_pose(spti_pkg::MODE_REQ, 48'd0));
    send_item(make_pose(spti_pkg::MODE_REQ, 48'd0));
    send_item(make_pose(spti_pkg::MODE_REQ, 48'd0));

    run_random(250);
    pressure_go = 1'b1;
    run_random(100);
    write_capacity(spti_pkg::REG_REF_CAP, 32'd0);
    write_capacity(spti_pkg::REG_SEN_CAP, 32'd0);
    run_random(200);
    write_capacity(spti_pkg::REG_REF_CAP, 32'd5);
    write_capacity(spti_pkg::REG_SEN_CAP, 32'd3);
    run_random(200);
    write_capacity(spti_pkg::REG_REF_CAP, 32'hffffffff);
    write_capacity(spti_pkg::REG_SEN_CAP, 32'd100);
    run_random(200);
    write_capacity(spti_pkg::REG_REF_CAP, 32'd16);
    write_capacity(spti_pkg::REG_SEN_CAP, 32'd8);
    run_random(200);
    in_valid = 1'b0;
    stim_done = 1'b1;

    wait (sb.expected_poses.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d input transfers and %0d results under five capacity settings.",
             n_items, sb.checked);
    $display("Results: %0d interpolated, %0d too few references, %0d uncovered, %0d mismatches.",
             sb.n_ok, sb.n_few, sb.n_uncovered, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_poses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
